// File: design/h2fhs_pkg.sv
// Shared types, constants and helper functions for the HTTP/2 frame header scanner.
`default_nettype none

package h2fhs_pkg;

  localparam int PREFACE_BYTES = 24;
  localparam int OFFSET_BITS   = 32;
  localparam int QUEUE_DEPTH   = 4;
  localparam int HDR_BYTES     = 9;

  // record kinds
  localparam logic [1:0] KIND_PREFACE    = 2'd0;
  localparam logic [1:0] KIND_HEADER     = 2'd1;
  localparam logic [1:0] KIND_INCOMPLETE = 2'd2;

  // raw frame type codes on the wire
  localparam logic [7:0] FT_DATA          = 8'h00;
  localparam logic [7:0] FT_HEADERS       = 8'h01;
  localparam logic [7:0] FT_SETTINGS      = 8'h04;
  localparam logic [7:0] FT_PING          = 8'h06;
  localparam logic [7:0] FT_GOAWAY        = 8'h07;
  localparam logic [7:0] FT_WINDOW_UPDATE = 8'h08;

  // type classes as reported
  localparam logic [2:0] CLS_DATA          = 3'd0;
  localparam logic [2:0] CLS_HEADERS       = 3'd1;
  localparam logic [2:0] CLS_SETTINGS      = 3'd2;
  localparam logic [2:0] CLS_PING          = 3'd3;
  localparam logic [2:0] CLS_WINDOW_UPDATE = 3'd4;
  localparam logic [2:0] CLS_GOAWAY        = 3'd5;
  localparam logic [2:0] CLS_OTHER         = 3'd6;

  localparam logic [7:0] FLAG_END_STREAM  = 8'h01;
  localparam logic [7:0] FLAG_END_HEADERS = 8'h04;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] offset;
    logic [24:0] length;
    logic [2:0]  ftype;
    logic        es;
    logic        eh;
    logic [30:0] sid;
  } h2fhs_rec_t;

  // one queue entry: the records caused by one byte (one or two)
  typedef struct packed {
    h2fhs_rec_t rec0;
    h2fhs_rec_t rec1;
    logic       two;
  } h2fhs_entry_t;

  function automatic logic [7:0] preface_byte(input logic [4:0] idx);
    logic [7:0] v;
    unique case (idx)
      5'd0:  v = 8'h50;
      5'd1:  v = 8'h52;
      5'd2:  v = 8'h49;
      5'd3:  v = 8'h20;
      5'd4:  v = 8'h2A;
      5'd5:  v = 8'h20;
      5'd6:  v = 8'h48;
      5'd7:  v = 8'h54;
      5'd8:  v = 8'h54;
      5'd9:  v = 8'h50;
      5'd10: v = 8'h2F;
      5'd11: v = 8'h32;
      5'd12: v = 8'h2E;
      5'd13: v = 8'h30;
      5'd14: v = 8'h0D;
      5'd15: v = 8'h0A;
      5'd16: v = 8'h0D;
      5'd17: v = 8'h0A;
      5'd18: v = 8'h53;
      5'd19: v = 8'h4D;
      5'd20: v = 8'h0D;
      5'd21: v = 8'h0A;
      5'd22: v = 8'h0D;
      5'd23: v = 8'h0A;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [2:0] type_class(input logic [7:0] t);
    logic [2:0] c;
    unique case (t)
      FT_DATA:          c = CLS_DATA;
      FT_HEADERS:       c = CLS_HEADERS;
      FT_SETTINGS:      c = CLS_SETTINGS;
      FT_PING:          c = CLS_PING;
      FT_WINDOW_UPDATE: c = CLS_WINDOW_UPDATE;
      FT_GOAWAY:        c = CLS_GOAWAY;
      default:          c = CLS_OTHER;
    endcase
    return c;
  endfunction

  // packed header: [30:0] stream, [31] end_headers, [32] end_stream,
  // [35:33] type class, [59:36] payload length
  function automatic h2fhs_rec_t header_rec(input logic [31:0] off, input logic [63:0] h);
    h2fhs_rec_t r;
    r.kind   = KIND_HEADER;
    r.offset = off;
    r.length = 25'(h[59:36]) + 25'(HDR_BYTES);
    r.ftype  = h[35:33];
    r.es     = h[32];
    r.eh     = h[31];
    r.sid    = h[30:0];
    return r;
  endfunction

  function automatic h2fhs_rec_t plain_rec(input logic [1:0] kind, input logic [31:0] off,
                                           input logic [24:0] len);
    h2fhs_rec_t r;
    r        = '0;
    r.kind   = kind;
    r.offset = off;
    r.length = len;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: design/http2_frame_header_scanner_unit.sv
// Top level of the HTTP/2 frame header scanner.
// Accepts one byte per cycle while the queue is not full; a byte's records go through the
// record queue to the output register. Output gives one record per cycle while out_ready is
// high; the record queue (QUEUE_DEPTH entries) absorbs two-record bytes and output stalls.
// Synchronous active-high reset empties the queue and output stage, zeroes the offset and
// re-arms the preface match; the same scanner restart follows every end-of-buffer byte.
`default_nettype none

module http2_frame_header_scanner_unit
  import h2fhs_pkg::*;
#(
  parameter int OFFSET_BITS = h2fhs_pkg::OFFSET_BITS,
  parameter int QUEUE_DEPTH = h2fhs_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        end_of_buffer,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       record_kind,
  output logic [31:0]      frame_offset,
  output logic [24:0]      frame_length,
  output logic [2:0]       frame_type,
  output logic             end_stream,
  output logic             end_headers,
  output logic [30:0]      stream_number,
  output logic             last_record
);

  logic         q_full, q_push, q_pop, q_empty;
  h2fhs_entry_t q_in, q_head;
  h2fhs_rec_t   rec;

  h2fhs_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
    .clk           (clk),
    .rst           (rst),
    .data_byte     (data_byte),
    .end_of_buffer (end_of_buffer),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_entry       (q_in)
  );

  h2fhs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty)
  );

  h2fhs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (q_head),
    .empty     (q_empty),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rec   (rec),
    .out_last  (last_record)
  );

  assign record_kind   = rec.kind;
  assign frame_offset  = rec.offset;
  assign frame_length  = rec.length;
  assign frame_type    = rec.ftype;
  assign end_stream    = rec.es;
  assign end_headers   = rec.eh;
  assign stream_number = rec.sid;

endmodule

`default_nettype wire

// File: design/h2fhs_front.sv
// Front end: byte acceptance, preface match, header capture and payload skip.
`default_nettype none

module h2fhs_front
  import h2fhs_pkg::*;
#(
  parameter int OFFSET_BITS = h2fhs_pkg::OFFSET_BITS
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic [7:0]   data_byte,
  input  wire logic         end_of_buffer,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic         q_full,
  output logic              q_push,
  output h2fhs_entry_t      q_entry
);

  logic [OFFSET_BITS-1:0] pos, pos_next;
  logic [4:0]             pf_idx, pf_idx_next;
  logic                   pf_match, pf_match_next;
  logic [3:0]             hdr_cnt, hdr_cnt_next;
  logic [63:0]            cap, cap_next;
  logic [OFFSET_BITS-1:0] cur_off, cur_off_next;
  logic [23:0]            pay_rem, pay_rem_next;
  logic                   held, held_next;

  logic accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    logic        complete;
    logic        failed;
    logic        hdr_done;
    logic [63:0] new_hdr;
    logic [2:0]  cls;
    logic [7:0]  flg;
    logic        emit_held;
    logic        emit_new;
    logic        emit_inc;
    logic [31:0] off32;
    h2fhs_rec_t  rec_held;
    h2fhs_rec_t  rec_new;
    h2fhs_rec_t  rec_inc;

    complete      = 1'b0;
    failed        = 1'b0;
    hdr_done      = 1'b0;
    new_hdr       = '0;
    cls           = CLS_OTHER;
    flg           = '0;
    emit_held     = 1'b0;
    emit_new      = 1'b0;
    emit_inc      = 1'b0;
    rec_held      = '0;
    pos_next      = pos + 1'b1;
    pf_idx_next   = pf_idx;
    pf_match_next = pf_match;
    hdr_cnt_next  = hdr_cnt;
    cap_next      = cap;
    cur_off_next  = cur_off;
    pay_rem_next  = pay_rem;
    held_next     = held;
    q_push        = 1'b0;
    q_entry       = '0;

    if (pf_match) begin
      if (pf_idx < 5'(PREFACE_BYTES) && data_byte == preface_byte(pf_idx)) begin
        pf_idx_next = pf_idx + 5'd1;
        complete    = (pf_idx_next == 5'(PREFACE_BYTES));
      end else begin
        failed = 1'b1;
      end
      if (end_of_buffer && !complete) failed = 1'b1;
    end

    if (complete) begin
      pf_match_next = 1'b0;
      held_next     = 1'b0;
      hdr_cnt_next  = '0;
      pay_rem_next  = '0;
      cap_next      = '0;
      cur_off_next  = OFFSET_BITS'(PREFACE_BYTES);
    end else begin
      if (hdr_cnt == 4'd0 && pay_rem == 24'd0) cur_off_next = pos;
      if (hdr_cnt == 4'd0 && pay_rem != 24'd0) begin
        pay_rem_next = pay_rem - 24'd1;
      end else if (hdr_cnt < 4'd8) begin
        cap_next     = {cap[55:0], data_byte};
        hdr_cnt_next = hdr_cnt + 4'd1;
      end else begin
        cls = type_class(cap[39:32]);
        flg = cap[31:24];
        new_hdr[59:36] = cap[63:40];
        new_hdr[35:33] = cls;
        if (cls == CLS_DATA || cls == CLS_HEADERS) begin
          new_hdr[32] = |(flg & FLAG_END_STREAM);
          new_hdr[31] = |(flg & FLAG_END_HEADERS);
        end
        new_hdr[30:0] = {cap[22:0], data_byte};
        hdr_done      = 1'b1;
        hdr_cnt_next  = '0;
        pay_rem_next  = cap[63:40];
      end

      if (failed) begin
        pf_match_next = 1'b0;
        if (held) begin
          emit_held = 1'b1;
          held_next = 1'b0;
        end
      end

      // the held header reads the capture register as it stands after this byte
      rec_held = header_rec(32'd0, cap_next);

      if (hdr_done) begin
        if (pf_match_next) begin
          cap_next  = new_hdr;
          held_next = 1'b1;
        end else begin
          cap_next = '0;
          emit_new = 1'b1;
        end
      end

      emit_inc = end_of_buffer && !(emit_held && emit_new) &&
                 (hdr_cnt_next != 4'd0 || pay_rem_next != 24'd0);
    end

    off32   = 32'(cur_off_next);
    rec_new = header_rec(off32, new_hdr);
    rec_inc = plain_rec(KIND_INCOMPLETE, off32, 25'd0);

    if (complete) begin
      q_push        = 1'b1;
      q_entry.rec0  = plain_rec(KIND_PREFACE, 32'd0, 25'(PREFACE_BYTES));
    end else if (emit_held) begin
      q_push       = 1'b1;
      q_entry.rec0 = rec_held;
      if (emit_new) begin
        q_entry.rec1 = rec_new;
        q_entry.two  = 1'b1;
      end else if (emit_inc) begin
        q_entry.rec1 = rec_inc;
        q_entry.two  = 1'b1;
      end
    end else if (emit_new) begin
      q_push       = 1'b1;
      q_entry.rec0 = rec_new;
      if (emit_inc) begin
        q_entry.rec1 = rec_inc;
        q_entry.two  = 1'b1;
      end
    end else if (emit_inc) begin
      q_push       = 1'b1;
      q_entry.rec0 = rec_inc;
    end

    if (!accept) q_push = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && end_of_buffer)) begin
      pos      <= '0;
      pf_idx   <= '0;
      pf_match <= 1'b1;
      hdr_cnt  <= '0;
      cap      <= '0;
      cur_off  <= '0;
      pay_rem  <= '0;
      held     <= 1'b0;
    end else if (accept) begin
      pos      <= pos_next;
      pf_idx   <= pf_idx_next;
      pf_match <= pf_match_next;
      hdr_cnt  <= hdr_cnt_next;
      cap      <= cap_next;
      cur_off  <= cur_off_next;
      pay_rem  <= pay_rem_next;
      held     <= held_next;
    end
  end

endmodule

`default_nettype wire

// File: design/h2fhs_queue.sv
// Short record queue between the scanning front end and the output back end.
`default_nettype none

module h2fhs_queue
  import h2fhs_pkg::*;
#(
  parameter int DEPTH = h2fhs_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire h2fhs_entry_t  push_entry,
  output logic               full,
  input  wire logic          pop,
  output h2fhs_entry_t       head,
  output logic               empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  h2fhs_entry_t  store [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign head    = store[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) store[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: design/h2fhs_back.sv
// Back end: splits queue entries into single records and drives the output register.
`default_nettype none

module h2fhs_back
  import h2fhs_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire h2fhs_entry_t  head,
  input  wire logic          empty,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output h2fhs_rec_t         out_rec,
  output logic               out_last
);

  h2fhs_rec_t pend;
  logic       pend_valid;
  logic       can_load;

  assign can_load = !out_valid || out_ready;
  assign pop      = can_load && !pend_valid && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (can_load) begin
      if (pend_valid) begin
        out_valid  <= 1'b1;
        out_rec    <= pend;
        out_last   <= 1'b1;
        pend_valid <= 1'b0;
      end else if (!empty) begin
        out_valid  <= 1'b1;
        out_rec    <= head.rec0;
        out_last   <= !head.two;
        pend       <= head.rec1;
        pend_valid <= head.two;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: bench/testbench.sv
// Self-checking bench for the HTTP/2 frame header scanner: byte driver, record monitor, predictor.
`default_nettype none

module testbench;
  import h2fhs_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       eob;
  } stream_byte_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] offset;
    logic [24:0] length;
    logic [2:0]  ftype;
    logic        es;
    logic        eh;
    logic [30:0] sid;
    logic        is_last;
  } frame_rec_t;

  localparam logic [0:23][7:0] PREFACE_TEXT = {
    8'h50, 8'h52, 8'h49, 8'h20, 8'h2A, 8'h20, 8'h48, 8'h54, 8'h54, 8'h50, 8'h2F, 8'h32,
    8'h2E, 8'h30, 8'h0D, 8'h0A, 8'h0D, 8'h0A, 8'h53, 8'h4D, 8'h0D, 8'h0A, 8'h0D, 8'h0A
  };
  localparam int ITEM_TARGET = 650;
  localparam int CALM_TAIL   = 80;   // no new idle gaps start once the backlog is at or below this

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        end_of_buffer = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  record_kind;
  logic [31:0] frame_offset;
  logic [24:0] frame_length;
  logic [2:0]  frame_type;
  logic        end_stream;
  logic        end_headers;
  logic [30:0] stream_number;
  logic        last_record;

  http2_frame_header_scanner_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .end_of_buffer(end_of_buffer),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .record_kind  (record_kind),
    .frame_offset (frame_offset),
    .frame_length (frame_length),
    .frame_type   (frame_type),
    .end_stream   (end_stream),
    .end_headers  (end_headers),
    .stream_number(stream_number),
    .last_record  (last_record)
  );

  stream_byte_t byte_backlog[$];
  logic [7:0]   pending_buffer[$];
  frame_rec_t   records_due[$];
  int           fail_count = 0;
  int           bytes_taken = 0;

  // scanner state mirror
  logic [31:0] scan_pos;
  logic [4:0]  pf_idx;
  bit          pf_live;
  logic [3:0]  hdr_cnt;
  logic [63:0] hdr_bits;
  logic [31:0] frm_start;
  logic [23:0] pay_left;
  bit          hdr_held;

  task automatic report_mismatch(input string what);
    fail_count++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  function automatic logic [2:0] type_to_class(input logic [7:0] t);
    case (t)
      FT_DATA:          return CLS_DATA;
      FT_HEADERS:       return CLS_HEADERS;
      FT_SETTINGS:      return CLS_SETTINGS;
      FT_PING:          return CLS_PING;
      FT_WINDOW_UPDATE: return CLS_WINDOW_UPDATE;
      FT_GOAWAY:        return CLS_GOAWAY;
      default:          return CLS_OTHER;
    endcase
  endfunction

  function automatic frame_rec_t plain_record(input logic [1:0] kind, input logic [31:0] off,
                                              input logic [24:0] len);
    frame_rec_t r;
    r = '0;
    r.kind   = kind;
    r.offset = off;
    r.length = len;
    return r;
  endfunction

  // packed header word: [59:36] length, [35:33] class, [32] es, [31] eh, [30:0] stream
  function automatic frame_rec_t header_record(input logic [31:0] off, input logic [63:0] h);
    frame_rec_t r;
    r = '0;
    r.kind   = KIND_HEADER;
    r.offset = off;
    r.length = 25'(h[59:36]) + 25'(HDR_BYTES);
    r.ftype  = h[35:33];
    r.es     = h[32];
    r.eh     = h[31];
    r.sid    = h[30:0];
    return r;
  endfunction

  task automatic clear_scan_state();
    scan_pos  = '0;
    pf_idx    = '0;
    pf_live   = 1'b1;
    hdr_cnt   = '0;
    hdr_bits  = '0;
    frm_start = '0;
    pay_left  = '0;
    hdr_held  = 1'b0;
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic eob);
    logic [31:0] p;
    bit          pf_done, pf_fail, hdr_done, es, eh;
    logic [63:0] new_hdr;
    logic [23:0] len;
    logic [2:0]  cls;
    logic [7:0]  flg;
    logic [30:0] sid;
    frame_rec_t  outs[2];
    int          n;
    p = scan_pos;
    pf_done = 0;
    pf_fail = 0;
    hdr_done = 0;
    new_hdr = '0;
    n = 0;
    if (pf_live) begin
      if (pf_idx < PREFACE_BYTES && b == PREFACE_TEXT[pf_idx]) begin
        pf_idx = pf_idx + 5'd1;
        if (pf_idx == PREFACE_BYTES) pf_done = 1;
      end else begin
        pf_fail = 1;
      end
      if (eob && !pf_done) pf_fail = 1;
    end
    if (pf_done) begin
      outs[n] = plain_record(KIND_PREFACE, '0, 25'(PREFACE_BYTES));
      n++;
      pf_live   = 0;
      hdr_held  = 0;
      hdr_cnt   = '0;
      pay_left  = '0;
      hdr_bits  = '0;
      frm_start = PREFACE_BYTES;
    end else begin
      if (hdr_cnt == 0 && pay_left == 0) frm_start = p;
      if (hdr_cnt == 0 && pay_left != 0) begin
        pay_left = pay_left - 24'd1;
      end else if (hdr_cnt < 8) begin
        hdr_bits = {hdr_bits[55:0], b};
        hdr_cnt  = hdr_cnt + 4'd1;
      end else begin
        len = hdr_bits[63:40];
        cls = type_to_class(hdr_bits[39:32]);
        flg = hdr_bits[31:24];
        sid = {hdr_bits[22:0], b};
        es  = 0;
        eh  = 0;
        if (cls == CLS_DATA || cls == CLS_HEADERS) begin
          es = (flg & FLAG_END_STREAM) != 0;
          eh = (flg & FLAG_END_HEADERS) != 0;
        end
        new_hdr  = {4'b0, len, cls, es, eh, sid};
        hdr_done = 1;
        hdr_cnt  = '0;
        pay_left = len;
      end
      if (pf_fail) begin
        pf_live = 0;
        // header held back during the preface match goes out first, at offset 0
        if (hdr_held) begin
          outs[n] = header_record('0, hdr_bits);
          n++;
          hdr_held = 0;
        end
      end
      if (hdr_done) begin
        if (pf_live) begin
          hdr_bits = new_hdr;
          hdr_held = 1;
        end else begin
          hdr_bits = '0;
          outs[n] = header_record(frm_start, new_hdr);
          n++;
        end
      end
      if (eob && n < 2 && (hdr_cnt != 0 || pay_left != 0)) begin
        outs[n] = plain_record(KIND_INCOMPLETE, frm_start, '0);
        n++;
      end
    end
    for (int i = 0; i < n; i++) begin
      outs[i].is_last = (i == n - 1);
      records_due.insert(records_due.size(), outs[i]);
    end
    if (eob) clear_scan_state();
    else scan_pos = p + 32'd1;
  endtask

  // ---- stimulus construction
  function automatic logic [7:0] pick_type();
    case ($urandom_range(0, 6))
      0: return FT_DATA;
      1: return FT_HEADERS;
      2: return FT_SETTINGS;
      3: return FT_PING;
      4: return FT_WINDOW_UPDATE;
      5: return FT_GOAWAY;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_byte(input logic [7:0] b);
    pending_buffer.insert(pending_buffer.size(), b);
  endtask

  task automatic add_header(input logic [23:0] len, input logic [7:0] typ, input logic [7:0] flg,
                            input logic [31:0] sid);
    add_byte(len[23:16]);
    add_byte(len[15:8]);
    add_byte(len[7:0]);
    add_byte(typ);
    add_byte(flg);
    add_byte(sid[31:24]);
    add_byte(sid[23:16]);
    add_byte(sid[15:8]);
    add_byte(sid[7:0]);
  endtask

  task automatic add_payload(input int count);
    for (int i = 0; i < count; i++) add_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic add_preface(input int count);
    for (int i = 0; i < count; i++) add_byte(PREFACE_TEXT[i]);
  endtask

  task automatic add_frames(input int count);
    logic [23:0] len;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 24) == 0) begin
        // oversized frame: the buffer ends inside its payload
        add_header(24'($urandom_range(13, 24'hFFFFFF)), pick_type(), 8'($urandom_range(0, 255)),
                   $urandom);
        add_payload($urandom_range(0, 8));
        break;
      end
      if ($urandom_range(0, 3) == 0) len = 24'd0;
      else if ($urandom_range(0, 9) == 0) len = 24'($urandom_range(13, 40));
      else len = 24'($urandom_range(1, 12));
      add_header(len, pick_type(), 8'($urandom_range(0, 255)), $urandom);
      add_payload(int'(len));
    end
  endtask

  // move the built buffer to the backlog, eob on its last byte; optionally cut short
  task automatic flush_buffer(input bit cut);
    stream_byte_t sb;
    int keep;
    keep = pending_buffer.size();
    if (cut && keep > 1) keep = $urandom_range(1, keep - 1);
    for (int i = 0; i < keep; i++) begin
      sb.data = pending_buffer[i];
      sb.eob  = (i == keep - 1);
      byte_backlog.insert(byte_backlog.size(), sb);
    end
    pending_buffer.delete();
  endtask

  task automatic add_random_buffer();
    int mode, k;
    mode = $urandom_range(0, 19);
    if (mode < 5) begin
      case ($urandom_range(0, 3))
        0: begin
          add_preface(PREFACE_BYTES);
          add_frames($urandom_range(1, 3));
          flush_buffer($urandom_range(0, 3) == 0);
        end
        1: begin
          add_preface(PREFACE_BYTES);
          flush_buffer(0);
        end
        2: begin
          // preface broken by one wrong byte
          k = $urandom_range(0, PREFACE_BYTES - 1);
          add_preface(k);
          add_byte(PREFACE_TEXT[k] ^ 8'($urandom_range(1, 255)));
          add_payload($urandom_range(0, 10));
          flush_buffer(0);
        end
        default: begin
          add_preface($urandom_range(1, PREFACE_BYTES - 1));
          flush_buffer(0);
        end
      endcase
    end else if (mode < 17) begin
      add_frames($urandom_range(1, 4));
      flush_buffer($urandom_range(0, 2) == 0);
    end else begin
      add_payload($urandom_range(1, 12));
      flush_buffer(0);
    end
  endtask

  // ---- clock
  initial begin
    forever #10 clk = ~clk;
  end

  // ---- byte driver
  int send_gap = 0;
  stream_byte_t next_byte;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
      clear_scan_state();
    end else begin
      if (in_valid && in_ready) begin
        scan_byte(data_byte, end_of_buffer);
        bytes_taken++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (byte_backlog.size() > CALM_TAIL && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(1, 16) - 1;
          in_valid <= 1'b0;
        end else if (byte_backlog.size() > 0) begin
          next_byte = byte_backlog.pop_front();
          in_valid      <= 1'b1;
          data_byte     <= next_byte.data;
          end_of_buffer <= next_byte.eob;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---- receiver readiness, with one long hold-off to back the block up
  int  recv_gap = 0;
  int  hold_left = 0;
  bit  hold_done = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (!hold_done && bytes_taken >= 200) begin
        hold_done = 1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else if (byte_backlog.size() > CALM_TAIL && $urandom_range(0, 9) == 0) begin
        recv_gap = $urandom_range(1, 16) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---- record monitor
  frame_rec_t got, want;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got = {record_kind, frame_offset, frame_length, frame_type, end_stream, end_headers,
             stream_number, last_record};
      if (records_due.size() == 0) begin
        report_mismatch($sformatf("unexpected record kind %0d offset %0d", got.kind, got.offset));
      end else begin
        want = records_due.pop_front();
        if (got.kind !== want.kind)
          report_mismatch($sformatf("record_kind %0d, want %0d", got.kind, want.kind));
        if (got.offset !== want.offset)
          report_mismatch($sformatf("frame_offset %0d, want %0d", got.offset, want.offset));
        if (got.length !== want.length)
          report_mismatch($sformatf("frame_length %0d, want %0d", got.length, want.length));
        if (got.ftype !== want.ftype)
          report_mismatch($sformatf("frame_type %0d, want %0d", got.ftype, want.ftype));
        if (got.es !== want.es)
          report_mismatch($sformatf("end_stream %0b, want %0b", got.es, want.es));
        if (got.eh !== want.eh)
          report_mismatch($sformatf("end_headers %0b, want %0b", got.eh, want.eh));
        if (got.sid !== want.sid)
          report_mismatch($sformatf("stream_number %0h, want %0h", got.sid, want.sid));
        if (got.is_last !== want.is_last)
          report_mismatch($sformatf("last_record %0b, want %0b", got.is_last, want.is_last));
      end
    end
  end

  // ---- stimulus and end of run
  initial begin
    // zero length field, reserved stream bit set, all flags
    add_header(24'h000000, FT_HEADERS, 8'hFF, 32'hFFFF_FFFF);
    flush_buffer(0);
    // header completes on the last byte with payload due: header plus incomplete together
    add_header(24'hFFFFFF, 8'hFF, 8'hFF, 32'h0000_0000);
    flush_buffer(0);
    // buffer ends during the preface match
    add_preface(3);
    flush_buffer(0);
    // lone byte buffer
    add_byte(8'h00);
    flush_buffer(0);
    while (byte_backlog.size() < ITEM_TARGET) add_random_buffer();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (byte_backlog.size() != 0 || in_valid) @(posedge clk);
    while (records_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
